// ===== sv/kwmf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwmf_pkg
// Shared constants and types for the keypoint window median filter.
// ----------------------------------------------------------------------------
package kwmf_pkg;

	// configuration of the filter
	localparam int WINDOW     = 5;
	localparam int NUM_POINTS = 21;
	localparam int COORDS     = 3;

	// field widths
	localparam int IDX_W   = 5;
	localparam int COORD_W = 32;
	localparam int DATA_W  = COORDS * COORD_W;

	// row address into the history memory
	localparam int ADDR_W = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;

	// rank counters and the sorted position that is reported
	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam logic [CNT_W-1:0] MED_POS = CNT_W'(WINDOW / 2);

	// point count as a limit for the index field, one bit wider
	localparam logic [IDX_W:0] PTS_LIM = (IDX_W + 1)'(NUM_POINTS);

	typedef logic [COORD_W-1:0] word_t;
	// one sample: x in element 0, then y, then z
	typedef word_t [COORDS-1:0] sample_t;
	// one keypoint history: newest sample in element 0
	typedef sample_t [WINDOW-1:0] row_t;
	// one coordinate over the window
	typedef word_t [WINDOW-1:0] column_t;

endpackage

// ===== sv/keypoint_window_median_filter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypoint_window_median_filter_unit
// Per-keypoint sliding-window median of x, y and z coordinates.
// ----------------------------------------------------------------------------
// Input channel s_*: one item per keypoint sample, index in s_tuser and the
// three Q16.16 coordinates in s_tdata. Output channel m_*: one item per input
// item, the echoed index in m_tuser and the three window medians in m_tdata.
// An index at or above the point count leaves the history untouched and
// returns zero medians.
// From input accept to m_tvalid an item passes the registered history-memory
// read, then shift, rank select and the output register. Throughput is one
// item per cycle while the receiver keeps m_tready high, also for
// back-to-back samples of the same keypoint (the last written row is
// forwarded past the memory).
// Reset clears the per-keypoint valid bits at once, so every history reads
// as all zero afterwards; no clearing pass is needed and the block is ready
// in the first cycle after reset.
// When m_tready is low the result holds in the output register and one more
// item can still be taken into the pipeline stage; after that s_tready drops
// until the receiver takes the result.
// ----------------------------------------------------------------------------
module keypoint_window_median_filter_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [kwmf_pkg::DATA_W-1:0]  s_tdata,   // coord_x, coord_y, coord_z
	input  logic [kwmf_pkg::IDX_W-1:0]   s_tuser,   // point_index
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [kwmf_pkg::DATA_W-1:0]  m_tdata,   // median_x, median_y, median_z
	output logic [kwmf_pkg::IDX_W-1:0]   m_tuser    // out_index
);
	import kwmf_pkg::*;

	// history memory and per-row valid bits
	row_t                  hist_mem_q [NUM_POINTS];
	logic [NUM_POINTS-1:0] row_vld_q;
	row_t                  wr_row_q;

	// pipeline stage
	logic                  valid_s1;
	logic [IDX_W-1:0]      idx_s1;
	sample_t               sample_s1;
	logic                  inrange_s1;
	logic                  bypass_s1;
	logic                  rowv_s1;
	row_t                  rd_row_s1;

	// output register
	logic                  m_tvalid_q;
	logic [DATA_W-1:0]     m_tdata_q;
	logic [IDX_W-1:0]      m_tuser_q;

	logic                  in_acc;
	logic                  in_range;
	logic [ADDR_W-1:0]     in_addr;
	logic [ADDR_W-1:0]     addr_s1;
	logic                  adv_s1;
	logic                  wr_en;
	row_t                  old_row;
	row_t                  new_row;
	column_t               col [COORDS];
	sample_t               med;

	// handshake
	assign adv_s1   = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign in_acc   = s_tvalid && s_tready;

	assign in_range = {1'b0, s_tuser} < PTS_LIM;
	assign in_addr  = ADDR_W'(s_tuser);
	assign addr_s1  = ADDR_W'(idx_s1);
	assign wr_en    = adv_s1 && inrange_s1;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			m_tvalid_q <= 1'b0;
			row_vld_q  <= '0;
		end else begin
			if (in_acc)
				valid_s1 <= 1'b1;
			else if (adv_s1)
				valid_s1 <= 1'b0;
			if (adv_s1)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			if (wr_en)
				row_vld_q[addr_s1] <= 1'b1;
		end
	end

	// capture the item, its history row and the forwarding decision
	always_ff @(posedge clk) begin
		if (in_acc) begin
			idx_s1     <= s_tuser;
			sample_s1  <= sample_t'(s_tdata);
			inrange_s1 <= in_range;
			bypass_s1  <= wr_en && (idx_s1 == s_tuser);
			rowv_s1    <= in_range && row_vld_q[in_addr];
		end
	end

	// history memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en)
			hist_mem_q[addr_s1] <= new_row;
		if (in_acc && in_range)
			rd_row_s1 <= hist_mem_q[in_addr];
	end

	// last written row, for a sample that follows on the same keypoint
	always_ff @(posedge clk) begin
		if (wr_en)
			wr_row_q <= new_row;
	end

	// shift the new sample into the window
	always_comb begin
		if (bypass_s1)
			old_row = wr_row_q;
		else if (rowv_s1)
			old_row = rd_row_s1;
		else
			old_row = '0;
		new_row[0] = sample_s1;
		for (int k = 1; k < WINDOW; k++)
			new_row[k] = old_row[k-1];
		for (int c = 0; c < COORDS; c++)
			for (int k = 0; k < WINDOW; k++)
				col[c][k] = new_row[k][c];
	end

	// one rank selector per coordinate
	for (genvar c = 0; c < COORDS; c++) begin : g_med
		kwmf_median u_med (
			.vals (col[c]),
			.med  (med[c])
		);
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			m_tuser_q <= idx_s1;
			m_tdata_q <= inrange_s1 ? DATA_W'(med) : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ===== sv/kwmf_median.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwmf_median
// Rank-select median of one coordinate over the window, combinational.
// ----------------------------------------------------------------------------
module kwmf_median (
	input  kwmf_pkg::column_t vals,
	output kwmf_pkg::word_t   med
);
	import kwmf_pkg::*;

	logic [CNT_W-1:0] below     [WINDOW];
	logic [CNT_W-1:0] not_above [WINDOW];
	logic             found;

	// rank of every element by signed compare against every element of the window
	always_comb begin
		for (int i = 0; i < WINDOW; i++) begin
			below[i]     = '0;
			not_above[i] = '0;
			for (int j = 0; j < WINDOW; j++) begin
				if ($signed(vals[j]) < $signed(vals[i]))
					below[i] = below[i] + CNT_W'(1);
				if ($signed(vals[j]) <= $signed(vals[i]))
					not_above[i] = not_above[i] + CNT_W'(1);
			end
		end
	end

	// first element whose rank range covers the median position
	always_comb begin
		med   = '0;
		found = 1'b0;
		for (int i = 0; i < WINDOW; i++) begin
			if (!found && below[i] <= MED_POS && MED_POS < not_above[i]) begin
				med   = vals[i];
				found = 1'b1;
			end
		end
	end

endmodule

// ===== sv/kwmf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwmf_checker
// Port-level checks for the keypoint window median filter.
// ----------------------------------------------------------------------------
module kwmf_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [kwmf_pkg::DATA_W-1:0]  m_tdata,
	input logic [kwmf_pkg::IDX_W-1:0]   m_tuser
);
	import kwmf_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// with the output register empty the input side is never blocked
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked while output empty");

	// after an accept, m_tvalid is high once the pipeline stage and output register are passed
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> ##1 m_tvalid)
		else $error("accepted item did not reach the output");

	// an out-of-range keypoint gives zero medians
	a_oob: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ({1'b0, m_tuser} >= PTS_LIM) |-> m_tdata == '0)
		else $error("nonzero medians for out-of-range keypoint");

endmodule

bind keypoint_window_median_filter_unit kwmf_checker u_kwmf_checker (.*);

// ===== tb/sv/keypoint_window_median_filter_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypoint_window_median_filter_unit_tb
// Self-checking bench for the per-keypoint sliding-window median filter.
// ----------------------------------------------------------------------------
// Keypoint samples go in on the s_* stream and the window medians come back
// on the m_* stream. Every accepted sample updates a private copy of the
// per-keypoint histories. The expected medians are queued and compared field
// by field with each result in order. A directed opening covers the
// coordinate extremes, the zero-filled early windows, repeated values and
// out-of-range indices. Random keypoint tracks with jitter, outliers and
// back-to-back repeats follow, run under several sender and receiver
// stall mixes.
// ----------------------------------------------------------------------------
module keypoint_window_median_filter_unit_tb;
	import kwmf_pkg::*;

	localparam int CLK_HALF    = 4;
	localparam int RESET_CYC   = 11;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYC   = 20;
	localparam int RAND_ITEMS  = 1030;
	localparam int NUM_PHASES  = 4;
	localparam int MAX_REPORTS = 10;

	localparam word_t W_MAX  = 32'h7FFF_FFFF;
	localparam word_t W_MIN  = 32'h8000_0000;
	localparam word_t W_ZERO = 32'h0000_0000;
	localparam word_t W_ONE  = 32'h0000_0001;
	localparam word_t W_NEG1 = 32'hFFFF_FFFF;

	// expected result: echoed index and x/y/z medians (x in element 0)
	typedef struct packed {
		logic [IDX_W-1:0] point_idx;
		sample_t          med;
	} median_result_t;

	// ------------------------------------------------------------------------
	// Median predictor and result checker
	// ------------------------------------------------------------------------
	class median_scoreboard;
		word_t          history [NUM_POINTS][WINDOW][COORDS];
		median_result_t pending_medians [$];
		int             samples_noted;
		int             results_checked;
		int             ignored_samples;
		int             mismatches;

		function new();
			foreach (history[p, k, c])
				history[p][k][c] = '0;
			samples_noted   = 0;
			results_checked = 0;
			ignored_samples = 0;
			mismatches      = 0;
		endfunction

		// sort a copy of the column by signed value and take the middle slot
		function word_t window_median(column_t col);
			logic signed [COORD_W-1:0] sorted [WINDOW];
			logic signed [COORD_W-1:0] tmp;
			for (int k = 0; k < WINDOW; k++)
				sorted[k] = col[k];
			for (int a = 0; a < WINDOW - 1; a++)
				for (int b = 0; b < WINDOW - 1 - a; b++)
					if (sorted[b] > sorted[b + 1]) begin
						tmp           = sorted[b];
						sorted[b]     = sorted[b + 1];
						sorted[b + 1] = tmp;
					end
			return word_t'(sorted[WINDOW / 2]);
		endfunction

		// accepted sample: shift history, queue the medians it produces
		function void note_sample(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
			median_result_t want;
			sample_t        smp;
			column_t        col;
			smp            = data;
			want.point_idx = idx;
			want.med       = '0;
			samples_noted++;
			if (idx >= NUM_POINTS) begin
				// out-of-range keypoint: history untouched, zero medians
				ignored_samples++;
			end else begin
				for (int k = WINDOW - 1; k > 0; k--)
					for (int c = 0; c < COORDS; c++)
						history[idx][k][c] = history[idx][k - 1][c];
				for (int c = 0; c < COORDS; c++)
					history[idx][0][c] = smp[c];
				for (int c = 0; c < COORDS; c++) begin
					for (int k = 0; k < WINDOW; k++)
						col[k] = history[idx][k][c];
					want.med[c] = window_median(col);
				end
			end
			pending_medians = {pending_medians, want};
		endfunction

		function void flag(string what, logic [COORD_W-1:0] want, logic [COORD_W-1:0] got);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t ns: mismatch on %s, expected %h, got %h",
					$time, what, want, got);
		endfunction

		// result taken by the receiver: compare against the oldest prediction
		function void check_medians(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
			median_result_t want;
			sample_t        got;
			got = data;
			if (pending_medians.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t ns: result for keypoint %0d with nothing pending",
						$time, idx);
				return;
			end
			want = pending_medians.pop_front();
			results_checked++;
			if (idx !== want.point_idx)
				flag("out_index", COORD_W'(want.point_idx), COORD_W'(idx));
			for (int c = 0; c < COORDS; c++)
				if (got[c] !== want.med[c])
					flag($sformatf("median_%s", (c == 0) ? "x" : (c == 1) ? "y" : "z"),
						want.med[c], got[c]);
		endfunction

		function int pending_count();
			return pending_medians.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Signals and block under test
	// ------------------------------------------------------------------------
	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata  = '0;   // coord_x, coord_y, coord_z
	logic [IDX_W-1:0]  s_tuser  = '0;   // point_index
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;         // median_x, median_y, median_z
	logic [IDX_W-1:0]  m_tuser;         // out_index

	int sender_idle_pct = 0;
	int recv_stall_pct  = 0;
	int quiet_cycles    = 0;

	median_scoreboard sb = new();

	keypoint_window_median_filter_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #CLK_HALF clk = ~clk;

	// receiver backpressure, decided fresh every cycle
	always @(negedge clk) begin
		if (arst_n)
			m_tready = ($urandom_range(99) >= recv_stall_pct);
	end

	// both handshakes observed at the rising edge, plus the stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_sample(s_tuser, s_tdata);
			if (m_tvalid && m_tready)
				sb.check_medians(m_tuser, m_tdata);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("%0t ns: no item moved for %0d cycles", $time, STALL_LIMIT);
					$display("** keypoint_window_median_filter_unit: FAILED **");
					$finish;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	function automatic sample_t pack_xyz(word_t x, word_t y, word_t z);
		sample_t s;
		s[0] = x;
		s[1] = y;
		s[2] = z;
		return s;
	endfunction

	// present one item from a falling edge and hold it until taken
	task automatic send_item(input logic [IDX_W-1:0] idx, input sample_t xyz);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = idx;
		s_tdata  = xyz;
		forever begin
			@(posedge clk);
			if (s_tready)
				break;
		end
		@(negedge clk);
	endtask

	// coordinate near a track base: mostly jitter, sometimes outlier or extreme
	function automatic word_t track_coord(word_t base);
		int pick;
		pick = $urandom_range(99);
		if (pick < 70)
			return base + word_t'($signed($urandom_range(256)) - 128);
		else if (pick < 80)
			return base;
		else if (pick < 92)
			return word_t'($urandom);
		else
			case ($urandom_range(3))
				0:       return W_MAX;
				1:       return W_MIN;
				2:       return W_ZERO;
				default: return W_NEG1;
			endcase
	endfunction

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int                sent;
		int                burst;
		int                pick;
		logic [IDX_W-1:0]  idx;
		word_t             bx;
		word_t             by;
		word_t             bz;

		repeat (RESET_CYC) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// keypoint 0: extremes through a window that starts zero filled
		send_item(5'd0, pack_xyz(W_MAX, W_MIN, W_ZERO));
		send_item(5'd0, pack_xyz(W_MIN, W_MAX, W_NEG1));
		send_item(5'd0, pack_xyz(W_MAX, W_MIN, W_ONE));
		send_item(5'd0, pack_xyz(W_NEG1, W_ONE, W_MAX));
		send_item(5'd0, pack_xyz(W_MIN, W_ZERO, W_MIN));
		send_item(5'd0, pack_xyz(W_ONE, W_NEG1, W_ZERO));
		// last keypoint: repeated identical values
		repeat (5)
			send_item(5'd20, pack_xyz(32'h1234_5678, 32'hFFFF_FFFB, 32'h7FFF_0000));
		// out-of-range keypoints leave all history alone (one keypoint 20 sample in between)
		send_item(5'd31, pack_xyz(W_MAX, W_MAX, W_MAX));
		send_item(5'd21, pack_xyz(W_MIN, W_NEG1, W_ONE));
		send_item(5'd20, pack_xyz(W_MIN, W_MIN, W_MIN));
		send_item(5'd30, pack_xyz(W_NEG1, W_NEG1, W_NEG1));
		// keypoint 16: x runs ascending while y runs descending
		send_item(5'd16, pack_xyz(32'hFFFE_0000, 32'h0003_0000, W_NEG1));
		send_item(5'd16, pack_xyz(32'hFFFF_0000, 32'h0002_0000, W_NEG1));
		send_item(5'd16, pack_xyz(32'h0001_0000, 32'h0001_0000, W_ONE));
		send_item(5'd16, pack_xyz(32'h0002_0000, W_ZERO, W_ONE));
		send_item(5'd16, pack_xyz(32'h0003_0000, 32'hFFFF_0000, W_ZERO));
		send_item(5'd15, pack_xyz(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F));

		// random tracks under four stall mixes
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin sender_idle_pct = 75; recv_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  recv_stall_pct = 75; end
				default: begin sender_idle_pct = 21; recv_stall_pct = 21; end
			endcase
			sent = 0;
			while (sent < RAND_ITEMS / NUM_PHASES) begin
				pick = $urandom_range(99);
				if (pick < 70) begin
					// one keypoint tracked over several back-to-back samples
					idx   = IDX_W'($urandom_range(NUM_POINTS - 1));
					bx    = $urandom;
					by    = $urandom;
					bz    = $urandom;
					burst = $urandom_range(8, 1);
					repeat (burst) begin
						send_item(idx, pack_xyz(track_coord(bx), track_coord(by),
							track_coord(bz)));
						sent++;
					end
				end else if (pick < 92) begin
					send_item(IDX_W'($urandom_range(NUM_POINTS - 1)),
						pack_xyz($urandom, $urandom, $urandom));
					sent++;
				end else begin
					send_item(IDX_W'($urandom_range((1 << IDX_W) - 1, NUM_POINTS)),
						pack_xyz($urandom, $urandom, $urandom));
					sent++;
				end
			end
		end
		s_tvalid = 1'b0;

		// drain, then give the pipeline time to show any stray result
		recv_stall_pct = 0;
		while (sb.pending_count() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		$display("Covered %0d samples (%0d with an out-of-range index), %0d results checked,",
			sb.samples_noted, sb.ignored_samples, sb.results_checked);
		$display("under free-running, sender-idle, receiver-stall and mixed handshakes.");
		if (sb.mismatches == 0 && sb.pending_count() == 0) begin
			$display("** keypoint_window_median_filter_unit: PASSED **");
		end else begin
			$display("%0d mismatches, %0d results never arrived",
				sb.mismatches, sb.pending_count());
			$display("** keypoint_window_median_filter_unit: FAILED **");
		end
		$finish;
	end

endmodule
